// ===== rtl/fixed_block_pool_allocator_core_macros.svh =====
// Assertion macros used by the allocator checker
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FBPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FBPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// Shared constants, codes and types of the block pool allocator
`default_nettype none

package fbpa_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned PoolDepth = 1024;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CntW      = 11;
  localparam int unsigned LinkW     = IdxW + 1;

  localparam int unsigned LimitInt  = (MaxBlocks < PoolDepth) ? MaxBlocks : PoolDepth;
  localparam logic [CntW-1:0] BlockLimit  = CntW'(LimitInt);
  localparam logic [CntW-1:0] EndMax      = {CntW{1'b1}};
  localparam logic [CntW-1:0] ResetChunk  = CntW'(4);

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusExhausted = 2'd1,
    StatusBadFree   = 2'd2
  } status_e;

  typedef enum logic {
    StateIdle = 1'b0,
    StatePop  = 1'b1
  } state_e;

  // frontier tracker view seen by the request logic
  typedef struct packed {
    logic [CntW-1:0] frontier;
    logic [CntW-1:0] count;
    logic [CntW-1:0] count_adv;
  } front_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fbpa_in_if.sv =====
// Request channel: opcode and block index of a free
`default_nettype none

interface fbpa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [fbpa_pkg::IdxW-1:0]     free_index;

  modport source (output valid, output opcode, output free_index, input ready);
  modport sink   (input valid, input opcode, input free_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbpa_out_if.sv =====
// Response channel: handed-out block, status and open chunk count
`default_nettype none

interface fbpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::IdxW-1:0]     block_index;
  logic [1:0]                    status;
  logic [fbpa_pkg::CntW-1:0]     chunks_in_use;

  modport source (output valid, output block_index, output status, output chunks_in_use,
                  input ready);
  modport sink   (input valid, input block_index, input status, input chunks_in_use,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Results: a free, a frontier allocate or a failed request is in the result register in the
// cycle after acceptance; an allocate from the free list passes through the Pop state first.
// Throughput: one word per cycle while the response side takes results, but a free-list allocate
// holds off the next word while the head's next link comes out of the link memory read port.
// Reset: control, list head, frontier and chunk state clear; the link memory is not
// cleared and needs no clearing pass.
`default_nettype none

module fixed_block_pool_allocator_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [fbpa_pkg::CntW-1:0] cfg_wdata_i,
  fbpa_in_if.sink                        req_i,
  fbpa_out_if.source                     rsp_o
);

  fbpa_pkg::state_e          state_q, state_d;
  logic [fbpa_pkg::IdxW-1:0] head_q, head_d;
  logic                      nonempty_q, nonempty_d;

  logic                      out_valid_q, out_valid_d;
  logic [fbpa_pkg::IdxW-1:0] out_block_q, out_block_d;
  fbpa_pkg::status_e         out_status_q, out_status_d;
  logic [fbpa_pkg::CntW-1:0] out_count_q, out_count_d;

  fbpa_pkg::front_stat_t     fstat;
  logic [fbpa_pkg::LinkW-1:0] link_rdata;

  logic in_ready, accept, is_alloc, pop, exhausted, take, bad_free, push;
  logic ram_we, ram_re, load;

  assign in_ready  = (state_q == fbpa_pkg::StateIdle) && (!out_valid_q || rsp_o.ready);
  assign accept    = req_i.valid && in_ready;
  assign is_alloc  = (fbpa_pkg::op_e'(req_i.opcode) == fbpa_pkg::OpAlloc);
  assign pop       = is_alloc && nonempty_q;
  assign exhausted = is_alloc && !nonempty_q && (fstat.frontier >= fbpa_pkg::BlockLimit);
  assign take      = is_alloc && !nonempty_q && !exhausted;
  assign bad_free  = !is_alloc && ({1'b0, req_i.free_index} >= fstat.frontier);
  assign push      = !is_alloc && !bad_free;

  fbpa_frontier u_frontier (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (accept && take),
    .stat_o      (fstat)
  );

  // each entry holds the pushed-over head and whether that head was live
  fbpa_ram #(
    .Width (fbpa_pkg::LinkW),
    .Depth (fbpa_pkg::PoolDepth)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.free_index),
    .wdata_i ({nonempty_q, head_q}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fbpa_pkg::StateIdle: begin
        if (accept && pop) begin
          state_d = fbpa_pkg::StatePop;
        end
      end
      fbpa_pkg::StatePop: begin
        state_d = fbpa_pkg::StateIdle;
      end
      default: begin
        state_d = fbpa_pkg::StateIdle;
      end
    endcase
  end

  // datapath control and result load
  always_comb begin
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    load         = 1'b0;
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    out_block_d  = out_block_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    case (state_q)
      fbpa_pkg::StateIdle: begin
        if (accept) begin
          if (pop) begin
            ram_re = 1'b1;
          end else begin
            load         = 1'b1;
            out_block_d  = take ? fstat.frontier[fbpa_pkg::IdxW-1:0] : '0;
            out_count_d  = take ? fstat.count_adv : fstat.count;
            out_status_d = exhausted ? fbpa_pkg::StatusExhausted :
                           bad_free  ? fbpa_pkg::StatusBadFree : fbpa_pkg::StatusOk;
            if (push) begin
              ram_we     = 1'b1;
              head_d     = req_i.free_index;
              nonempty_d = 1'b1;
            end
          end
        end
      end
      fbpa_pkg::StatePop: begin
        // hand out the old head, advance to its link
        load         = 1'b1;
        out_block_d  = head_q;
        out_count_d  = fstat.count;
        out_status_d = fbpa_pkg::StatusOk;
        head_d       = link_rdata[fbpa_pkg::IdxW-1:0];
        nonempty_d   = link_rdata[fbpa_pkg::IdxW];
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::StateIdle;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_block_q  <= out_block_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign req_i.ready         = in_ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_index   = out_block_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.chunks_in_use = out_count_q;

endmodule

`default_nettype wire

// ===== rtl/fbpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module fbpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbpa_frontier.sv =====
// Lazy frontier and chunk bookkeeping, plus the chunk size register
`default_nettype none

module fbpa_frontier (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [fbpa_pkg::CntW-1:0] cfg_wdata_i,
  input  wire logic                      advance_i,
  output fbpa_pkg::front_stat_t          stat_o
);

  logic [fbpa_pkg::CntW-1:0] frontier_q, frontier_d;
  logic [fbpa_pkg::CntW-1:0] count_q, count_d;
  logic [fbpa_pkg::CntW-1:0] end_q, end_d;
  logic [fbpa_pkg::CntW-1:0] blocks_q, blocks_d;
  logic [fbpa_pkg::CntW-1:0] size_cur, size_new;
  logic [fbpa_pkg::CntW:0]   end_sum;
  logic                      at_end;

  // a chunk size of zero acts as one
  assign size_cur = (blocks_q == '0) ? fbpa_pkg::CntW'(1) : blocks_q;
  assign size_new = (cfg_wdata_i == '0) ? fbpa_pkg::CntW'(1) : cfg_wdata_i;
  assign at_end   = (frontier_q >= end_q);
  assign end_sum  = {1'b0, end_q} + {1'b0, size_cur};

  always_comb begin
    frontier_d = frontier_q;
    count_d    = count_q;
    end_d      = end_q;
    blocks_d   = blocks_q;
    if (cfg_we_i) begin
      blocks_d = cfg_wdata_i;
      // reload the first chunk end only before any block is touched
      if (frontier_q == '0) begin
        end_d = size_new;
      end
    end else if (advance_i) begin
      frontier_d = frontier_q + fbpa_pkg::CntW'(1);
      if (at_end) begin
        end_d   = end_sum[fbpa_pkg::CntW] ? fbpa_pkg::EndMax : end_sum[fbpa_pkg::CntW-1:0];
        count_d = count_q + fbpa_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frontier_q <= '0;
      count_q    <= fbpa_pkg::CntW'(1);
      end_q      <= fbpa_pkg::ResetChunk;
      blocks_q   <= fbpa_pkg::ResetChunk;
    end else begin
      frontier_q <= frontier_d;
      count_q    <= count_d;
      end_q      <= end_d;
      blocks_q   <= blocks_d;
    end
  end

  assign stat_o.frontier  = frontier_q;
  assign stat_o.count     = count_q;
  assign stat_o.count_adv = at_end ? (count_q + fbpa_pkg::CntW'(1)) : count_q;

endmodule

`default_nettype wire

// ===== rtl/fbpa_checker.sv =====
// Port-level checks on the allocator and their binding to the top level
`default_nettype none
`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      rsp_valid_i,
  input wire logic                      rsp_ready_i,
  input wire logic [fbpa_pkg::IdxW-1:0] rsp_block_i,
  input wire logic [1:0]                rsp_status_i,
  input wire logic [fbpa_pkg::CntW-1:0] rsp_count_i
);

  // a stalled word holds
  `FBPA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_block_i) && $stable(rsp_status_i) && $stable(rsp_count_i), "response changed while stalled")
  `FBPA_ASSERT_IMP(a_status_code, clk_i, rst_ni, rsp_valid_i, rsp_status_i == fbpa_pkg::StatusOk || rsp_status_i == fbpa_pkg::StatusExhausted || rsp_status_i == fbpa_pkg::StatusBadFree, "undefined status code")
  `FBPA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, rsp_valid_i && rsp_status_i != fbpa_pkg::StatusOk, rsp_block_i == '0, "failed request returned a block")
  `FBPA_ASSERT_IMP(a_chunk_open, clk_i, rst_ni, rsp_valid_i, rsp_count_i != '0, "no chunk reported open")

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_block_i (rsp_o.block_index),
  .rsp_status_i(rsp_o.status),
  .rsp_count_i (rsp_o.chunks_in_use)
);

`default_nettype wire

// ===== tb/sv/tb_fixed_block_pool_allocator_core.sv =====
// Self-checking testbench for the fixed block pool allocator core
module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] block;
    status_e         status;
    logic [CntW-1:0] chunks;
  } pool_result_t;

  typedef enum bit {
    RowReq = 1'b0,
    RowCfg = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    op_e             op;
    logic [CntW-1:0] arg;
    bit              typed;
    pool_result_t    want;
  } dir_row_t;

  localparam int DirRows = 20;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;

  fbpa_in_if  req_if ();
  fbpa_out_if rsp_if ();

  fixed_block_pool_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Allocator state as the predictor sees it
  bit [IdxW-1:0]   link_mem  [PoolDepth];
  bit              link_live [PoolDepth];
  logic [IdxW-1:0] head_q       = '0;
  logic            list_live    = 1'b0;
  logic [CntW-1:0] front_q      = '0;
  logic [CntW-1:0] chunks_open  = CntW'(1);
  logic [CntW-1:0] chunk_size_q = ResetChunk;
  logic [CntW-1:0] chunk_end_q  = ResetChunk;

  pool_result_t    due_results [$];
  logic [IdxW-1:0] held [$];
  int              fail_count   = 0;
  int              results_seen = 0;
  int              items_sent   = 0;
  int              exhaust_hits = 0;

  // Frees at 0 and 1023 before any block exists, then zero chunk size, then size 3
  dir_row_t dir_table [DirRows] = '{
    '{RowReq, OpFree,  11'd0,    1'b1, '{10'd0, StatusBadFree, 11'd1}},
    '{RowReq, OpFree,  11'd1023, 1'b1, '{10'd0, StatusBadFree, 11'd1}},
    '{RowCfg, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd1023, 1'b1, '{10'd0, StatusOk, 11'd1}},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd512,  1'b0, '0},
    '{RowCfg, OpAlloc, 11'd3,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpFree,  11'd5,    1'b1, '{10'd0, StatusBadFree, 11'd4}},
    '{RowReq, OpFree,  11'd1,    1'b0, '0},
    '{RowReq, OpFree,  11'd4,    1'b0, '0},
    '{RowReq, OpFree,  11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0},
    '{RowReq, OpFree,  11'd6,    1'b0, '0},
    '{RowReq, OpAlloc, 11'd0,    1'b0, '0}
  };

  function automatic pool_result_t pool_step(op_e op, logic [IdxW-1:0] idx);
    pool_result_t    res;
    logic [CntW:0]   grown;
    logic [CntW-1:0] span;
    res.block  = '0;
    res.status = StatusOk;
    span = (chunk_size_q == '0) ? CntW'(1) : chunk_size_q;
    if (op == OpAlloc) begin
      if (list_live) begin
        res.block = head_q;
        head_q    = link_mem[res.block];
        list_live = link_live[res.block];
      end else if (front_q >= BlockLimit) begin
        res.status = StatusExhausted;
      end else begin
        // open a new chunk once the frontier reaches the end of the current one
        if (front_q >= chunk_end_q) begin
          grown = {1'b0, chunk_end_q} + {1'b0, span};
          chunk_end_q = (grown > {1'b0, EndMax}) ? EndMax : grown[CntW-1:0];
          chunks_open = chunks_open + CntW'(1);
        end
        res.block = front_q[IdxW-1:0];
        front_q   = front_q + CntW'(1);
      end
    end else if ({1'b0, idx} >= front_q) begin
      res.status = StatusBadFree;
    end else begin
      link_mem[idx]  = head_q;
      link_live[idx] = list_live;
      head_q         = idx;
      list_live      = 1'b1;
    end
    res.chunks = chunks_open;
    return res;
  endfunction

  function automatic void set_chunk_blocks(logic [CntW-1:0] value);
    chunk_size_q = value;
    if (front_q == '0) chunk_end_q = (value == '0) ? CntW'(1) : value;
  endfunction

  task automatic flag(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Offer one word, hold it until accepted, then predict its result
  task automatic send_word(op_e op, logic [IdxW-1:0] idx, bit typed, pool_result_t want);
    pool_result_t got;
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.free_index <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    got = pool_step(op, idx);
    due_results.insert(due_results.size(), typed ? want : got);
    items_sent++;
    if (got.status == StatusExhausted) exhaust_hits++;
    if (got.status == StatusOk) begin
      if (op == OpAlloc) begin
        held.insert(held.size(), got.block);
      end else begin
        foreach (held[k]) begin
          if (held[k] == idx) begin
            held.delete(k);
            break;
          end
        end
      end
    end
  endtask

  // Drain the block before touching the register
  task automatic write_chunk(logic [CntW-1:0] value);
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    set_chunk_blocks(value);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int count, int alloc_pct, bit until_exhausted);
    int              done_n;
    int              pick;
    op_e             op_sel;
    logic [IdxW-1:0] idx_sel;
    done_n = 0;
    while (until_exhausted ? (exhaust_hits < 6) : (done_n < count)) begin
      if (!(items_sent >= 600 && items_sent < 800) && $urandom_range(0, 99) < 7) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      op_sel  = OpAlloc;
      idx_sel = IdxW'($urandom_range(0, 1023));
      if ($urandom_range(0, 99) >= alloc_pct) begin
        if (held.size() != 0 && $urandom_range(0, 99) < 85) begin
          pick    = $urandom_range(0, held.size() - 1);
          op_sel  = OpFree;
          idx_sel = held[pick];
        end else if (front_q < BlockLimit) begin
          // free of a block past the frontier
          op_sel  = OpFree;
          idx_sel = IdxW'($urandom_range(front_q, 1023));
        end
      end
      send_word(op_sel, idx_sel, 1'b0, '0);
      done_n++;
    end
  endtask

  always @(posedge clk_i) begin : check_words
    pool_result_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        flag($sformatf("result %0d: word with nothing expected", results_seen));
      end else begin
        want = due_results.pop_front();
        if (rsp_if.block_index !== want.block || rsp_if.status !== want.status ||
            rsp_if.chunks_in_use !== want.chunks)
          flag($sformatf("result %0d: block %0d/%0d status %0d/%0d chunks %0d/%0d",
                         results_seen, want.block, rsp_if.block_index, want.status,
                         rsp_if.status, want.chunks, rsp_if.chunks_in_use));
      end
    end
  end

  // Response side: random stalls, one long hold-off, one stretch with none
  initial begin : pace_rsp
    bit held_off;
    held_off = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= 250) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        rsp_if.ready <= (results_seen >= 500 && results_seen < 700) ||
                        ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int              guard;
    logic [IdxW-1:0] twice;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.opcode     = 1'b0;
    req_if.free_index = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (dir_table[r].kind == RowCfg)
        write_chunk(dir_table[r].arg);
      else
        send_word(dir_table[r].op, dir_table[r].arg[IdxW-1:0], dir_table[r].typed,
                  dir_table[r].want);
    end

    write_chunk(CntW'($urandom_range(2, 8)));
    run_phase(60, 85, 1'b0);
    write_chunk(CntW'(1));
    run_phase(60, 85, 1'b0);
    write_chunk(CntW'($urandom_range(9, 64)));
    run_phase(60, 80, 1'b0);
    // next chunk opened saturates the chunk end; then run the pool dry
    write_chunk(EndMax);
    run_phase(0, 98, 1'b1);
    write_chunk(CntW'(1024));
    run_phase(20, 40, 1'b0);

    // double free last: it loops the free list for good
    twice = held[0];
    send_word(OpFree, twice, 1'b0, '0);
    send_word(OpFree, twice, 1'b0, '0);
    repeat (4) send_word(OpAlloc, '0, 1'b0, '0);
    req_if.valid <= 1'b0;

    guard = 0;
    while (due_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0)
      flag($sformatf("%0d expected words never arrived", due_results.size()));

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
